### hw/rtl/lge_pkg.sv
// ----------------------------------------------------------------------------
// Life grid package
// Shared widths, register indexes, operation codes, rule counts, controller
// states and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lge_pkg;

   localparam int DEF_MAX_ROWS    = 64;
   localparam int DEF_MAX_COLUMNS = 64;

   localparam int CFG_WIDTH       = 7;
   localparam int OPERATION_WIDTH = 2;
   localparam int INDEX_WIDTH     = 6;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GRID_HEIGHT = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GRID_WIDTH  = 1'd1;

   localparam logic [CFG_WIDTH-1:0] GRID_HEIGHT_RESET = 7'd10;
   localparam logic [CFG_WIDTH-1:0] GRID_WIDTH_RESET  = 7'd20;

   localparam logic [OPERATION_WIDTH-1:0] OP_WRITE   = 2'd0;
   localparam logic [OPERATION_WIDTH-1:0] OP_READ    = 2'd1;
   localparam logic [OPERATION_WIDTH-1:0] OP_ADVANCE = 2'd2;

   // B3/S23: a live cell survives with two or three neighbors, a dead cell
   // is born with exactly three.
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_ACC_DATA,
      ST_ADV_FILL,
      ST_ADV_ROW,
      ST_RESPOND
   } ctrl_state_type;

   typedef struct packed {
      logic clear_write;
      logic capture_req;
      logic capture_status;
      logic acc_finish;
      logic adv_prime;
      logic adv_fill;
      logic adv_row;
      logic rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic op_write;
      logic op_read;
      logic op_advance;
      logic in_range;
      logic rows_zero;
      logic last_row;
      logic rsp_free;
   } ctrl_sts_type;

endpackage

### hw/rtl/lge_chan_if.sv
// ----------------------------------------------------------------------------
// Life grid channels
// Request and response valid/ready channels with their payload fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lge_req_if;
   logic                                valid;
   logic                                ready;
   logic [lge_pkg::OPERATION_WIDTH-1:0] operation;
   logic [lge_pkg::INDEX_WIDTH-1:0]     row_index;
   logic [lge_pkg::INDEX_WIDTH-1:0]     column_index;
   logic                                cell_value;

   modport source (output valid, output operation, output row_index,
                   output column_index, output cell_value, input ready);
   modport sink   (input valid, input operation, input row_index,
                   input column_index, input cell_value, output ready);
endinterface

interface lge_rsp_if;
   logic valid;
   logic ready;
   logic read_value;
   logic status;

   modport source (output valid, output read_value, output status, input ready);
   modport sink   (input valid, input read_value, input status, output ready);
endinterface

### hw/rtl/lge_ctrl.sv
// ----------------------------------------------------------------------------
// Life grid controller
// Sequences the clearing pass, cell accesses, generation sweeps and responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lge_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output lge_pkg::ctrl_cmd_type cmd,
   input  lge_pkg::ctrl_sts_type sts
);
   import lge_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.capture_req = req_valid;
            if (req_valid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            cmd.capture_status = 1'b1;
            priority if (sts.op_write || sts.op_read) begin
               state_in = sts.in_range ? ST_ACC_DATA : ST_RESPOND;
            end else if (sts.op_advance && !sts.rows_zero) begin
               cmd.adv_prime = 1'b1;
               state_in      = ST_ADV_FILL;
            end else begin
               state_in = ST_RESPOND;
            end
         end
         ST_ACC_DATA: begin
            cmd.acc_finish = 1'b1;
            state_in       = ST_RESPOND;
         end
         ST_ADV_FILL: begin
            cmd.adv_fill = 1'b1;
            state_in     = ST_ADV_ROW;
         end
         ST_ADV_ROW: begin
            cmd.adv_row = 1'b1;
            if (sts.last_row) begin
               state_in = ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_single_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_write, cmd.acc_finish, cmd.adv_row}))
      else $error("more than one grid memory write source active");

   a_sweep_has_rows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADV_ROW) |-> !sts.rows_zero)
      else $error("generation sweep running on an empty grid");

   a_clear_ends_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && sts.clear_done) |=> (state_ff == ST_IDLE))
      else $error("clearing pass did not hand over to idle");

endmodule

### hw/rtl/lge_datapath.sv
// ----------------------------------------------------------------------------
// Life grid datapath
// Size registers, grid memory, row sweep registers, next-generation logic
// and the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lge_datapath #(
   parameter int MAX_ROWS    = lge_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLUMNS = lge_pkg::DEF_MAX_COLUMNS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [lge_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [lge_pkg::CFG_WIDTH-1:0]       csr_write_data,
   input  logic [lge_pkg::OPERATION_WIDTH-1:0] req_operation,
   input  logic [lge_pkg::INDEX_WIDTH-1:0]     req_row_index,
   input  logic [lge_pkg::INDEX_WIDTH-1:0]     req_column_index,
   input  logic                                req_cell_value,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic                                rsp_read_value,
   output logic                                rsp_status,
   input  lge_pkg::ctrl_cmd_type               cmd,
   output lge_pkg::ctrl_sts_type               sts
);
   import lge_pkg::*;

   localparam int RAW = $clog2(MAX_ROWS);
   localparam int CAW = $clog2(MAX_COLUMNS);
   localparam int RNW = (RAW + 1 > CFG_WIDTH) ? RAW + 1 : CFG_WIDTH;
   localparam int CNW = (CAW + 1 > CFG_WIDTH) ? CAW + 1 : CFG_WIDTH;

   logic [CFG_WIDTH-1:0] height_ff, height_in;
   logic [CFG_WIDTH-1:0] width_ff, width_in;

   logic [OPERATION_WIDTH-1:0] op_ff, op_in;
   logic [INDEX_WIDTH-1:0]     row_ff, row_in;
   logic [INDEX_WIDTH-1:0]     col_ff, col_in;
   logic                       val_ff, val_in;

   logic [RAW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [RAW:0]   row_cnt_ff, row_cnt_in;

   logic [MAX_COLUMNS-1:0] grid_mem [MAX_ROWS];
   logic [MAX_COLUMNS-1:0] rd_ff;
   logic [MAX_COLUMNS-1:0] prev_ff, prev_in;
   logic [MAX_COLUMNS-1:0] cur_ff, cur_in;

   logic res_value_ff, res_value_in;
   logic res_status_ff, res_status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_read_value_ff, rsp_read_value_in;
   logic rsp_status_ff, rsp_status_in;

   logic [RNW-1:0] height_ext, rows_use, row_ext, row_cnt_ext;
   logic [CNW-1:0] width_ext, cols_use, col_ext;
   logic [RAW-1:0] row_addr, raddr, waddr;
   logic [CAW-1:0] col_sel;
   logic [RAW:0]   row_cnt_plus2;
   logic           we, last_row, in_range;
   logic [MAX_COLUMNS-1:0] wdata, col_mask, next_row, new_row, acc_row;

   // Size registers saturate to the built grid.
   assign height_ext = RNW'(height_ff);
   assign width_ext  = CNW'(width_ff);
   assign rows_use   = (height_ext > RNW'(MAX_ROWS)) ? RNW'(MAX_ROWS) : height_ext;
   assign cols_use   = (width_ext > CNW'(MAX_COLUMNS)) ? CNW'(MAX_COLUMNS) : width_ext;

   assign row_ext  = RNW'(row_ff);
   assign col_ext  = CNW'(col_ff);
   assign row_addr = row_ext[RAW-1:0];
   assign col_sel  = col_ext[CAW-1:0];
   assign in_range = (row_ext < rows_use) && (col_ext < cols_use);

   assign row_cnt_ext   = RNW'(row_cnt_ff);
   assign last_row      = (row_cnt_ext + RNW'(1)) == rows_use;
   assign row_cnt_plus2 = row_cnt_ff + (RAW + 1)'(2);

   always_comb begin
      for (int c = 0; c < MAX_COLUMNS; c++) begin
         col_mask[c] = CNW'(c) < cols_use;
      end
   end

   // The row below counts only while it lies inside the grid in use.
   assign next_row = last_row ? '0 : rd_ff;

   always_comb begin : life_calc
      logic [MAX_COLUMNS+1:0] pe, qe, ne;
      logic [3:0]             cnt;
      pe = {1'b0, prev_ff & col_mask, 1'b0};
      qe = {1'b0, cur_ff & col_mask, 1'b0};
      ne = {1'b0, next_row & col_mask, 1'b0};
      new_row = cur_ff;
      for (int c = 0; c < MAX_COLUMNS; c++) begin
         cnt = 4'(pe[c]) + 4'(pe[c+1]) + 4'(pe[c+2]) + 4'(qe[c]) + 4'(qe[c+2])
             + 4'(ne[c]) + 4'(ne[c+1]) + 4'(ne[c+2]);
         if (col_mask[c]) begin
            new_row[c] = qe[c+1] ? (cnt == SURVIVE_COUNT || cnt == BIRTH_COUNT)
                                 : (cnt == BIRTH_COUNT);
         end
      end
   end

   always_comb begin
      acc_row          = rd_ff;
      acc_row[col_sel] = val_ff;
   end

   // Memory port selection.
   always_comb begin
      priority if (cmd.adv_prime) begin
         raddr = '0;
      end else if (cmd.adv_fill) begin
         raddr = RAW'(1);
      end else if (cmd.adv_row) begin
         raddr = row_cnt_plus2[RAW-1:0];
      end else begin
         raddr = row_addr;
      end
   end

   always_comb begin
      we    = 1'b0;
      waddr = row_addr;
      wdata = acc_row;
      priority if (cmd.clear_write) begin
         we    = 1'b1;
         waddr = clr_cnt_ff;
         wdata = '0;
      end else if (cmd.acc_finish && sts.op_write) begin
         we = 1'b1;
      end else if (cmd.adv_row) begin
         we    = 1'b1;
         waddr = row_cnt_ff[RAW-1:0];
         wdata = new_row;
      end else begin
         we = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         grid_mem[waddr] <= wdata;
      end
      rd_ff <= grid_mem[raddr];
   end

   always_comb begin
      height_in = height_ff;
      width_in  = width_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_GRID_HEIGHT: height_in = csr_write_data;
            REG_GRID_WIDTH:  width_in  = csr_write_data;
            default:         height_in = height_ff;
         endcase
      end
   end

   always_comb begin
      op_in  = cmd.capture_req ? req_operation : op_ff;
      row_in = cmd.capture_req ? req_row_index : row_ff;
      col_in = cmd.capture_req ? req_column_index : col_ff;
      val_in = cmd.capture_req ? req_cell_value : val_ff;

      clr_cnt_in = cmd.clear_write ? clr_cnt_ff + RAW'(1) : clr_cnt_ff;

      row_cnt_in = row_cnt_ff;
      prev_in    = prev_ff;
      cur_in     = cur_ff;
      if (cmd.adv_prime) begin
         row_cnt_in = '0;
      end
      if (cmd.adv_fill) begin
         prev_in = '0;
         cur_in  = rd_ff;
      end
      if (cmd.adv_row) begin
         row_cnt_in = row_cnt_ff + (RAW + 1)'(1);
         prev_in    = cur_ff;
         cur_in     = next_row;
      end

      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      if (cmd.capture_status) begin
         res_value_in  = 1'b0;
         res_status_in = (sts.op_write || sts.op_read) && !in_range;
      end
      if (cmd.acc_finish && sts.op_read) begin
         res_value_in = rd_ff[col_sel];
      end

      rsp_valid_in      = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);
      rsp_read_value_in = cmd.rsp_load ? res_value_ff : rsp_read_value_ff;
      rsp_status_in     = cmd.rsp_load ? res_status_ff : rsp_status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff    <= GRID_HEIGHT_RESET;
         width_ff     <= GRID_WIDTH_RESET;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         height_ff    <= height_in;
         width_ff     <= width_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff             <= op_in;
      row_ff            <= row_in;
      col_ff            <= col_in;
      val_ff            <= val_in;
      row_cnt_ff        <= row_cnt_in;
      prev_ff           <= prev_in;
      cur_ff            <= cur_in;
      res_value_ff      <= res_value_in;
      res_status_ff     <= res_status_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_status_ff     <= rsp_status_in;
   end

   always_comb begin
      sts.clear_done = clr_cnt_ff == RAW'(MAX_ROWS - 1);
      sts.op_write   = op_ff == OP_WRITE;
      sts.op_read    = op_ff == OP_READ;
      sts.op_advance = op_ff == OP_ADVANCE;
      sts.in_range   = in_range;
      sts.rows_zero  = rows_use == '0;
      sts.last_row   = last_row;
      sts.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;

   a_row_step: assert property (@(posedge clock) disable iff (reset)
      (cmd.adv_row && !last_row) |=> (row_cnt_ff == $past(row_cnt_ff) + (RAW + 1)'(1)))
      else $error("sweep row counter did not advance by one");

   a_error_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> !rsp_read_value_ff)
      else $error("error response carries a live cell");

   a_no_word_while_clearing: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_write |-> !rsp_valid_ff)
      else $error("response pending during the clearing pass");

endmodule

### hw/rtl/life_grid_generation_engine.sv
// ----------------------------------------------------------------------------
// Life grid generation engine
// Holds a grid of one-bit cells and runs Conway's B3/S23 rule on it.
// A request word on req_chan writes one cell, reads one cell or advances the
// whole grid one generation; every request word yields exactly one response
// word on rsp_chan with read_value and status (1 = row or column outside the
// configured grid). Cells beyond the grid edge count as dead, no wrap-around.
// grid_height and grid_width are written through csr_write_enable, csr_index
// and csr_write_data; the user must do so only while the engine is idle, as
// the block does not enforce it. Values above the built size saturate to it.
// One request is worked on at a time. A read or write inside the grid passes
// from dispatch through the cell access to the response word; one outside the
// grid, an unused code or an advance with zero rows in use goes from dispatch
// straight to the response word. An advance fills the sweep window and then
// sweeps the rows in use, reading and writing one row word per cycle in the
// row memory. The next request is taken in the cycle after the response word
// is loaded. After reset the grid memory is swept to dead, one row per cycle,
// and req_chan.ready stays low during that pass. A stalled receiver holds
// the response word in the output register; the engine finishes the next
// request's work and then waits until that register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module life_grid_generation_engine #(
   parameter int MAX_ROWS    = lge_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLUMNS = lge_pkg::DEF_MAX_COLUMNS
) (
   input  logic                                clock,
   input  logic                                reset,
   lge_req_if.sink                             req_chan,
   lge_rsp_if.source                           rsp_chan,
   input  logic                                csr_write_enable,
   input  logic [lge_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [lge_pkg::CFG_WIDTH-1:0]       csr_write_data
);
   import lge_pkg::*;

   // Command and status bundles are the only link between the controller
   // and the datapath.
   ctrl_cmd_type cmd;
   ctrl_sts_type sts;
   logic         ready;

   lge_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // The datapath owns the size registers, the grid memory, the three-row
   // sweep window and the response register.
   lge_datapath #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_operation    (req_chan.operation),
      .req_row_index    (req_chan.row_index),
      .req_column_index (req_chan.column_index),
      .req_cell_value   (req_chan.cell_value),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_read_value   (rsp_chan.read_value),
      .rsp_status       (rsp_chan.status),
      .cmd              (cmd),
      .sts              (sts)
   );

   assign req_chan.ready = ready;

endmodule
